// File: rtl/sccb_pkg.sv
// ----------------------------------------------------------------------------
// sccb_pkg
// Types and constants shared by the serial camera control bus master.
// ----------------------------------------------------------------------------
package sccb_pkg;

  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_HALF_PERIOD = 1'b1;

  localparam logic [7:0]  DEV_ADDR_RESET    = 8'd96;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
  localparam logic [7:0]  READ_ADDR_BIT     = 8'h01;

  typedef enum logic [19:0] {
    PH_IDLE   = 20'h00001,
    PH_ST_A   = 20'h00002,
    PH_ST_B   = 20'h00004,
    PH_BIT_LO = 20'h00008,
    PH_BIT_HI = 20'h00010,
    PH_ACK_LO = 20'h00020,
    PH_ACK_HI = 20'h00040,
    PH_GAP1   = 20'h00080,
    PH_GAP2   = 20'h00100,
    PH_SP_A   = 20'h00200,
    PH_SP_B   = 20'h00400,
    PH_SP_C   = 20'h00800,
    PH_RGAP1  = 20'h01000,
    PH_RGAP2  = 20'h02000,
    PH_RB_LO  = 20'h04000,
    PH_RB_HI  = 20'h08000,
    PH_NA_A   = 20'h10000,
    PH_NA_B   = 20'h20000,
    PH_NA_C   = 20'h40000,
    PH_NA_D   = 20'h80000
  } phase_e;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_fail;
    logic [7:0] rd_data;
  } res_t;

endpackage

// File: rtl/sccb_seq.sv
// ----------------------------------------------------------------------------
// sccb_seq
// Bus sequencer: holds the transaction phase, counters and line levels and
// works out the pin levels and status of one tick.
// ----------------------------------------------------------------------------
module sccb_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  logic [1:0]    opcode_i,
  input  logic [7:0]    reg_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          sda_in_i,
  input  logic [7:0]    dev_addr_i,
  input  logic [15:0]   half_period_i,
  output logic          idle_o,
  output sccb_pkg::res_t res_o
);
  import sccb_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [15:0] delay_q, delay_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  byte_idx_q, byte_idx_d;
  logic        nack_q, nack_d;
  logic [7:0]  rbyte_q, rbyte_d;
  logic        is_read_q, is_read_d;
  logic [7:0]  lreg_q, lreg_d;
  logic [7:0]  ldata_q, ldata_d;
  logic [2:0]  lines_q, lines_d;

  logic [15:0] len;
  logic [16:0] delay_inc;
  logic        step_end;
  logic        done;
  logic        start;

  function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic rd,
                                          input logic [7:0] dev, input logic [7:0] rg,
                                          input logic [7:0] dat);
    logic [7:0] b;
    if (idx == 2'd0) begin
      b = dev;
    end else if (idx == 2'd1) begin
      b = rg;
    end else if (rd) begin
      b = dev | READ_ADDR_BIT;
    end else begin
      b = dat;
    end
    return b;
  endfunction

  assign len    = (half_period_i == 16'd0) ? 16'd1 : half_period_i;
  assign idle_o = (phase_q == PH_IDLE);
  assign start  = (phase_q == PH_IDLE) && ((opcode_i == OP_WRITE) || (opcode_i == OP_READ));

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    delay_d    = delay_q;
    shift_d    = shift_q;
    byte_idx_d = byte_idx_q;
    nack_d     = nack_q;
    rbyte_d    = rbyte_q;
    is_read_d  = is_read_q;
    lreg_d     = lreg_q;
    ldata_d    = ldata_q;
    lines_d    = lines_q;
    done       = 1'b0;
    delay_inc  = 17'd0;
    step_end   = 1'b0;

    if (start) begin
      is_read_d  = (opcode_i == OP_READ);
      lreg_d     = reg_addr_i;
      ldata_d    = wr_data_i;
      byte_idx_d = 2'd0;
      bit_cnt_d  = 4'd0;
      nack_d     = 1'b0;
      rbyte_d    = 8'd0;
      delay_d    = 16'd0;
      shift_d    = dev_addr_i;
      phase_d    = PH_ST_A;
    end

    if (phase_d != PH_IDLE) begin
      unique case (phase_d)
        PH_ST_A:                lines_d = 3'b111;
        PH_ST_B:                lines_d = 3'b101;
        PH_BIT_LO:              lines_d = {1'b0, shift_d[7], 1'b1};
        PH_BIT_HI:              lines_d = {1'b1, shift_d[7], 1'b1};
        PH_ACK_LO, PH_RB_LO:    lines_d = {1'b0, lines_q[1], 1'b0};
        PH_ACK_HI, PH_RB_HI:    lines_d = {1'b1, lines_q[1], 1'b0};
        PH_GAP1, PH_GAP2,
        PH_NA_A:                lines_d = {1'b0, lines_q[1], 1'b1};
        PH_SP_A, PH_NA_D:       lines_d = 3'b001;
        PH_SP_B:                lines_d = 3'b101;
        PH_SP_C, PH_RGAP1,
        PH_RGAP2, PH_NA_B:      lines_d = 3'b111;
        PH_NA_C:                lines_d = 3'b011;
        default:                lines_d = lines_q;
      endcase

      if (phase_d == PH_ACK_HI && delay_d == len - 16'd1 && sda_in_i && !is_read_d) begin
        nack_d = 1'b1;
      end
      if (phase_d == PH_RB_HI && delay_d == 16'd0) begin
        rbyte_d = {rbyte_d[6:0], sda_in_i};
      end

      delay_inc = {1'b0, delay_d} + 17'd1;
      step_end  = (delay_inc >= {1'b0, len});
      delay_d   = step_end ? 16'd0 : delay_inc[15:0];

      if (step_end) begin
        unique case (phase_d)
          PH_ST_A:  phase_d = PH_ST_B;
          PH_ST_B: begin
            bit_cnt_d = 4'd0;
            phase_d   = PH_BIT_LO;
          end
          PH_BIT_LO: phase_d = PH_BIT_HI;
          PH_BIT_HI: begin
            shift_d   = {shift_d[6:0], 1'b0};
            bit_cnt_d = bit_cnt_d + 4'd1;
            phase_d   = (bit_cnt_d >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
          end
          PH_ACK_LO: phase_d = PH_ACK_HI;
          PH_ACK_HI: phase_d = (!is_read_d && byte_idx_d == 2'd2) ? PH_SP_A : PH_GAP1;
          PH_GAP1:   phase_d = PH_GAP2;
          PH_GAP2: begin
            if (!is_read_d || byte_idx_d == 2'd0) begin
              byte_idx_d = byte_idx_d + 2'd1;
              shift_d    = byte_for(byte_idx_d, is_read_d, dev_addr_i, lreg_d, ldata_d);
              bit_cnt_d  = 4'd0;
              phase_d    = PH_BIT_LO;
            end else if (byte_idx_d == 2'd1) begin
              phase_d = PH_SP_A;
            end else begin
              bit_cnt_d = 4'd0;
              rbyte_d   = 8'd0;
              phase_d   = PH_RB_LO;
            end
          end
          PH_SP_A:  phase_d = PH_SP_B;
          PH_SP_B:  phase_d = PH_SP_C;
          PH_SP_C: begin
            if (is_read_d && byte_idx_d == 2'd1) begin
              phase_d = PH_RGAP1;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          PH_RGAP1: phase_d = PH_RGAP2;
          PH_RGAP2: begin
            byte_idx_d = 2'd2;
            shift_d    = byte_for(2'd2, is_read_d, dev_addr_i, lreg_d, ldata_d);
            phase_d    = PH_ST_A;
          end
          PH_RB_LO: phase_d = PH_RB_HI;
          PH_RB_HI: begin
            bit_cnt_d = bit_cnt_d + 4'd1;
            phase_d   = (bit_cnt_d >= 4'd8) ? PH_NA_A : PH_RB_LO;
          end
          PH_NA_A:  phase_d = PH_NA_B;
          PH_NA_B:  phase_d = PH_NA_C;
          PH_NA_C:  phase_d = PH_NA_D;
          PH_NA_D:  phase_d = PH_SP_A;
          default:  phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res_o.scl_out   = lines_d[2];
    res_o.sda_out   = lines_d[1];
    res_o.sda_drive = lines_d[0];
    res_o.busy_res  = start || (phase_q != PH_IDLE);
    res_o.done_res  = done;
    res_o.ack_fail  = done && !is_read_d && nack_d;
    res_o.rd_data   = (done && is_read_d) ? rbyte_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_cnt_q  <= 4'd0;
      delay_q    <= 16'd0;
      shift_q    <= 8'd0;
      byte_idx_q <= 2'd0;
      nack_q     <= 1'b0;
      rbyte_q    <= 8'd0;
      is_read_q  <= 1'b0;
      lreg_q     <= 8'd0;
      ldata_q    <= 8'd0;
      lines_q    <= 3'b111;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      delay_q    <= delay_d;
      shift_q    <= shift_d;
      byte_idx_q <= byte_idx_d;
      nack_q     <= nack_d;
      rbyte_q    <= rbyte_d;
      is_read_q  <= is_read_d;
      lreg_q     <= lreg_d;
      ldata_q    <= ldata_d;
      lines_q    <= lines_d;
    end
  end

`ifndef SYNTHESIS
  a_busy_while_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> res_o.busy_res)
    else $error("sequencer active without busy");

  a_done_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && res_o.done_res) |=> (phase_q == PH_IDLE))
    else $error("sequencer not idle after done");

  a_delay_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> ({1'b0, delay_q} < {1'b0, len} || $past(step_en_i) == 1'b0
     || $changed(half_period_i) || $past(half_period_i) != half_period_i))
    else $error("delay counter past step length");
`endif

endmodule

// File: rtl/sccb_register_master_core.sv
// ----------------------------------------------------------------------------
// sccb_register_master_core
// Serial camera control bus register master. Each item is one tick that
// carries the sampled data line and may start a register write or read.
// ----------------------------------------------------------------------------
// The result of an item is registered and offered on the output in the
// cycle after the item is accepted. One item is taken per cycle while the
// output is not stalled; the output register lets a new item enter while the
// previous result is being taken. Reset clears the sequencer to idle with
// clock and data high and driven, and loads the register defaults.
module sccb_register_master_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  wr_data_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        sda_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        ack_fail_o,
  output logic [7:0]  rd_data_o
);
  import sccb_pkg::*;

  logic [7:0]  dev_addr_q;
  logic [15:0] half_period_q;
  logic        out_valid_q;
  res_t        res_q;
  res_t        res_d;
  logic        in_fire;
  logic        seq_idle;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RESET;
      half_period_q <= HALF_PERIOD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEV_ADDR:    dev_addr_q    <= cfg_data_i[7:0];
        CFG_HALF_PERIOD: half_period_q <= cfg_data_i;
        default:         dev_addr_q    <= dev_addr_q;
      endcase
    end
  end

  sccb_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (in_fire),
    .opcode_i      (opcode_i),
    .reg_addr_i    (reg_addr_i),
    .wr_data_i     (wr_data_i),
    .sda_in_i      (sda_in_i),
    .dev_addr_i    (dev_addr_q),
    .half_period_i (half_period_q),
    .idle_o        (seq_idle),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = res_q.scl_out;
  assign sda_out_o   = res_q.sda_out;
  assign sda_drive_o = res_q.sda_drive;
  assign busy_res_o  = res_q.busy_res;
  assign done_res_o  = res_q.done_res;
  assign ack_fail_o  = res_q.ack_fail;
  assign rd_data_o   = res_q.rd_data;

`ifndef SYNTHESIS
  a_done_has_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> busy_res_o)
    else $error("done reported without busy");

  a_status_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (ack_fail_o || rd_data_o != 8'd0)) |-> done_res_o)
    else $error("ack failure or read data without done");

  a_tick_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && seq_idle && opcode_i != OP_WRITE && opcode_i != OP_READ)
    |=> (out_valid_o && !busy_res_o))
    else $error("idle tick reported busy");
`endif

endmodule

// File: verif/sccb_tick_checker.sv
// ----------------------------------------------------------------------------
// sccb_tick_checker
// Watches the configuration, item and result channels of the camera control
// bus master. It keeps its own copy of the sequencer, computes the line levels
// and status that each accepted item must produce, and compares every
// accepted result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sccb_tick_checker
  import sccb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  wr_data_i,
  input  logic        sda_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  res_t        line_res_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          writes_done_o,
  output int          nacked_writes_o,
  output int          reads_done_o
);

  logic [7:0]  dev_addr_q = DEV_ADDR_RESET;
  logic [15:0] half_q     = HALF_PERIOD_RESET;

  phase_e      ph = PH_IDLE;
  logic [3:0]  bits;
  logic [15:0] dly;
  logic [7:0]  shreg;
  logic [1:0]  byte_idx;
  logic        nack;
  logic [7:0]  rx_byte;
  logic        rd_mode;
  logic [7:0]  reg_l;
  logic [7:0]  data_l;
  logic        scl_l;
  logic        sda_l;
  logic        drv_l;

  res_t line_results_q[$];
  res_t want;
  int   errors      = 0;
  int   writes_done = 0;
  int   nacked      = 0;
  int   reads_done  = 0;

  function automatic logic [7:0] wire_byte(input logic [1:0] idx);
    if (idx == 2'd0) return dev_addr_q;
    if (idx == 2'd1) return reg_l;
    if (rd_mode) return dev_addr_q | READ_ADDR_BIT;
    return data_l;
  endfunction

  function automatic void drive_lines();
    logic b;
    b = shreg[7];
    case (ph)
      PH_ST_A:            {scl_l, sda_l, drv_l} = 3'b111;
      PH_ST_B:            {scl_l, sda_l, drv_l} = 3'b101;
      PH_BIT_LO:          {scl_l, sda_l, drv_l} = {1'b0, b, 1'b1};
      PH_BIT_HI:          {scl_l, sda_l, drv_l} = {1'b1, b, 1'b1};
      PH_ACK_LO:          {scl_l, drv_l} = 2'b00;
      PH_ACK_HI:          {scl_l, drv_l} = 2'b10;
      PH_GAP1, PH_GAP2:   {scl_l, drv_l} = 2'b01;
      PH_SP_A:            {scl_l, sda_l, drv_l} = 3'b001;
      PH_SP_B:            {scl_l, sda_l, drv_l} = 3'b101;
      PH_SP_C:            {scl_l, sda_l, drv_l} = 3'b111;
      PH_RGAP1, PH_RGAP2: {scl_l, sda_l, drv_l} = 3'b111;
      PH_RB_LO:           {scl_l, drv_l} = 2'b00;
      PH_RB_HI:           {scl_l, drv_l} = 2'b10;
      PH_NA_A:            {scl_l, drv_l} = 2'b01;
      PH_NA_B:            {scl_l, sda_l, drv_l} = 3'b111;
      PH_NA_C:            {scl_l, sda_l, drv_l} = 3'b011;
      PH_NA_D:            {scl_l, sda_l, drv_l} = 3'b001;
      default: ;
    endcase
  endfunction

  // Moves to the next step once a step has lasted its half period.
  // Returns high when the stop sequence that ends the transfer completes.
  function automatic logic step_phase();
    logic fin;
    fin = 1'b0;
    case (ph)
      PH_ST_B: begin
        bits = 4'd0;
        ph = PH_BIT_LO;
      end
      PH_BIT_HI: begin
        shreg = shreg << 1;
        bits = bits + 4'd1;
        ph = (bits >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
      end
      PH_ACK_HI: ph = (!rd_mode && byte_idx == 2'd2) ? PH_SP_A : PH_GAP1;
      PH_GAP2: begin
        if (!rd_mode || byte_idx == 2'd0) begin
          byte_idx = byte_idx + 2'd1;
          shreg = wire_byte(byte_idx);
          bits = 4'd0;
          ph = PH_BIT_LO;
        end else if (byte_idx == 2'd1) begin
          ph = PH_SP_A;
        end else begin
          bits = 4'd0;
          rx_byte = 8'd0;
          ph = PH_RB_LO;
        end
      end
      PH_RB_HI: begin
        bits = bits + 4'd1;
        ph = (bits >= 4'd8) ? PH_NA_A : PH_RB_LO;
      end
      PH_NA_D: ph = PH_SP_A;
      PH_SP_C: begin
        if (rd_mode && byte_idx == 2'd1) begin
          ph = PH_RGAP1;
        end else begin
          ph = PH_IDLE;
          fin = 1'b1;
        end
      end
      PH_RGAP2: begin
        byte_idx = 2'd2;
        shreg = wire_byte(2'd2);
        ph = PH_ST_A;
      end
      default: ph = phase_e'(ph << 1);
    endcase
    return fin;
  endfunction

  task automatic sequence_tick(input logic [1:0] op, input logic [7:0] ra,
                               input logic [7:0] wd, input logic sda, output res_t r);
    logic [15:0] len;
    logic        fin;
    len = (half_q == 16'd0) ? 16'd1 : half_q;
    fin = 1'b0;
    r = '0;
    if (ph == PH_IDLE && (op == OP_WRITE || op == OP_READ)) begin
      rd_mode = (op == OP_READ);
      reg_l = ra;
      data_l = wd;
      byte_idx = 2'd0;
      bits = 4'd0;
      nack = 1'b0;
      rx_byte = 8'd0;
      dly = 16'd0;
      shreg = dev_addr_q;
      ph = PH_ST_A;
    end
    if (ph != PH_IDLE) begin
      r.busy_res = 1'b1;
      drive_lines();
      if (ph == PH_ACK_HI && dly == len - 16'd1 && sda && !rd_mode) nack = 1'b1;
      if (ph == PH_RB_HI && dly == 16'd0) rx_byte = {rx_byte[6:0], sda};
      dly = dly + 16'd1;
      if (dly >= len) begin
        dly = 16'd0;
        fin = step_phase();
      end
    end
    r.scl_out   = scl_l;
    r.sda_out   = sda_l;
    r.sda_drive = drv_l;
    r.done_res  = fin;
    r.ack_fail  = fin && !rd_mode && nack;
    r.rd_data   = (fin && rd_mode) ? rx_byte : 8'd0;
    if (fin && rd_mode) reads_done++;
    if (fin && !rd_mode) writes_done++;
    if (fin && !rd_mode && nack) nacked++;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q = DEV_ADDR_RESET;
      half_q = HALF_PERIOD_RESET;
      ph = PH_IDLE;
      bits = 4'd0;
      dly = 16'd0;
      shreg = 8'd0;
      byte_idx = 2'd0;
      nack = 1'b0;
      rx_byte = 8'd0;
      rd_mode = 1'b0;
      reg_l = 8'd0;
      data_l = 8'd0;
      {scl_l, sda_l, drv_l} = 3'b111;
      line_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_DEV_ADDR) dev_addr_q = cfg_data_i[7:0];
        else half_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (line_results_q.size() == 0) begin
          errors++;
          $display("%0t: result %h arrived with no item outstanding", $time, line_res_i);
        end else begin
          want = line_results_q.pop_front();
          check_field("scl_out", want.scl_out, line_res_i.scl_out);
          check_field("sda_out", want.sda_out, line_res_i.sda_out);
          check_field("sda_drive", want.sda_drive, line_res_i.sda_drive);
          check_field("busy_res", want.busy_res, line_res_i.busy_res);
          check_field("done_res", want.done_res, line_res_i.done_res);
          check_field("ack_fail", want.ack_fail, line_res_i.ack_fail);
          check_field("rd_data", want.rd_data, line_res_i.rd_data);
        end
      end
      if (in_valid_i && in_ready_i) begin
        sequence_tick(opcode_i, reg_addr_i, wr_data_i, sda_in_i, want);
        line_results_q.push_back(want);
      end
    end
    fail_count_o    <= errors;
    pending_o       <= line_results_q.size();
    writes_done_o   <= writes_done;
    nacked_writes_o <= nacked;
    reads_done_o    <= reads_done;
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the camera control bus master with tick items: a directed run through
// writes, failed acknowledges, reads, spare opcodes, requests while busy and
// extreme bus settings, then random traffic under several settings, most with
// random stalls on both sides. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import sccb_pkg::*;

  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         STALL_PCT   = 9;
  localparam int         QUIET_LIMIT = 2000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic        cfg_index   = CFG_DEV_ADDR;
  logic [15:0] cfg_data    = 16'd0;
  logic        in_valid    = 1'b0;
  logic [1:0]  opcode      = OP_TICK;
  logic [7:0]  reg_addr    = 8'd0;
  logic [7:0]  wr_data     = 8'd0;
  logic        sda_in      = 1'b0;
  logic        out_ready   = 1'b0;
  logic        idle_on     = 1'b1;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic        scl_out;
  logic        sda_out;
  logic        sda_drive;
  logic        busy_res;
  logic        done_res;
  logic        ack_fail;
  logic [7:0]  rd_data;
  res_t        line_res;

  int fail_count;
  int pending;
  int writes_done;
  int nacked_writes;
  int reads_done;
  int items_sent    = 0;
  int settings_used = 0;
  int quiet         = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sccb_register_master_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .reg_addr_i  (reg_addr),
    .wr_data_i   (wr_data),
    .sda_in_i    (sda_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .scl_out_o   (scl_out),
    .sda_out_o   (sda_out),
    .sda_drive_o (sda_drive),
    .busy_res_o  (busy_res),
    .done_res_o  (done_res),
    .ack_fail_o  (ack_fail),
    .rd_data_o   (rd_data)
  );

  assign line_res = {scl_out, sda_out, sda_drive, busy_res, done_res, ack_fail, rd_data};

  sccb_tick_checker line_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .reg_addr_i      (reg_addr),
    .wr_data_i       (wr_data),
    .sda_in_i        (sda_in),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .line_res_i      (line_res),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .writes_done_o   (writes_done),
    .nacked_writes_o (nacked_writes),
    .reads_done_o    (reads_done)
  );

  always @(posedge clk) begin
    out_ready <= !(idle_on && $urandom_range(0, 99) < STALL_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic pick_sda(input int high_pct);
    return $urandom_range(0, 99) < high_pct;
  endfunction

  task automatic push_tick(input logic [1:0] op, input logic [7:0] ra,
                           input logic [7:0] wd, input logic sda);
    while (idle_on && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    reg_addr <= ra;
    wr_data  <= wd;
    sda_in   <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic tick_until(input int base, input int high_pct);
    while (writes_done + reads_done == base) begin
      push_tick(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                pick_sda(high_pct));
    end
  endtask

  task automatic run_transfer(input logic [1:0] op, input logic [7:0] ra,
                              input logic [7:0] wd, input int high_pct);
    int base;
    base = writes_done + reads_done;
    push_tick(op, ra, wd, pick_sda(high_pct));
    tick_until(base, high_pct);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_bus(input logic [7:0] dev, input logic [15:0] half);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEV_ADDR;
    cfg_data  <= {8'd0, dev};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_HALF_PERIOD;
    cfg_data  <= half;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(input logic [7:0] dev, input logic [15:0] half, input int n,
                            input int high_pct, input logic idle);
    int         pick;
    logic [1:0] op;
    settle();
    set_bus(dev, half);
    idle_on <= idle;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      op = (pick < 70) ? OP_TICK : (pick < 84) ? OP_WRITE : (pick < 97) ? OP_READ : OP_SPARE;
      push_tick(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                pick_sda(high_pct));
    end
  endtask

  initial begin
    int base;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Start a write under the reset settings, then finish it with a zero
    // half period, which must behave like a half period of one.
    base = 0;
    push_tick(OP_WRITE, 8'h3C, 8'hC3, 1'b0);
    repeat (39) push_tick(OP_TICK, 8'h00, 8'h00, 1'b0);
    settle();
    set_bus(8'hFE, 16'd0);
    tick_until(base, 0);

    run_transfer(OP_WRITE, 8'hFF, 8'h00, 0);
    run_transfer(OP_WRITE, 8'h00, 8'hFF, 100);
    push_tick(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
    push_tick(OP_SPARE, 8'h00, 8'h00, 1'b0);
    run_transfer(OP_READ, 8'hA5, 8'h5A, 50);

    // A write request in the middle of a read must be ignored.
    base = writes_done + reads_done;
    push_tick(OP_READ, 8'h5A, 8'hA5, 1'b0);
    repeat (10) push_tick(OP_TICK, 8'h00, 8'h00, pick_sda(50));
    push_tick(OP_WRITE, 8'hFF, 8'hFF, 1'b0);
    tick_until(base, 50);

    settle();
    set_bus(8'h00, 16'd2);
    run_transfer(OP_READ, 8'h80, 8'h01, 100);
    run_transfer(OP_WRITE, 8'h01, 8'h80, 0);

    // Full-scale half period: begin a write, then shorten the period to finish.
    settle();
    set_bus(8'h00, 16'hFFFF);
    base = writes_done + reads_done;
    push_tick(OP_WRITE, 8'h7E, 8'h81, 1'b0);
    repeat (20) push_tick(OP_TICK, 8'h00, 8'h00, 1'b0);
    settle();
    set_bus(8'h00, 16'd1);
    tick_until(base, 0);

    run_random(8'($urandom_range(0, 254)), 16'd1, 40, 10, 1'b1);
    run_random(8'd254, 16'd2, 30, 50, 1'b0);
    run_random(8'($urandom_range(0, 254)), 16'd3, 30, 90, 1'b1);
    run_random(8'($urandom_range(0, 254)), 16'd1, 40, 5, 1'b1);

    settle();
    repeat (4) @(posedge clk);
    $display("Sent %0d tick items under %0d bus settings, zero and full-scale periods included.",
             items_sent, settings_used);
    $display("Saw %0d register writes (%0d not acknowledged) and %0d register reads complete.",
             writes_done, nacked_writes, reads_done);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
